// ----- rtl/core/isw_pkg.sv -----
// isw_pkg: types and constants shared by the indexed stack with erase
// holds the request and response item structs and the operation and status codes
// no dependencies
package isw_pkg;

    localparam int VALUE_W = 32;
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;

    // operation codes
    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_GET   = 2'd2,
        OP_ERASE = 2'd3
    } op_t;

    // status codes
    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2,
        STS_RANGE = 2'd3
    } status_t;

    // request item
    typedef struct packed {
        op_t                        op;
        logic signed [VALUE_W-1:0]  value;
        logic [INDEX_W-1:0]         index;
    } req_t;

    // response item
    typedef struct packed {
        logic signed [VALUE_W-1:0]  read_value;
        status_t                    status;
        logic [COUNT_W-1:0]         count;
    } rsp_t;

endpackage

// ----- rtl/core/isw_ram.sv -----
// isw_ram: simple dual-port element memory, one write and one read port
// read data is registered
// no dependencies
module isw_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/indexed_stack_with_erase.sv -----
// indexed_stack_with_erase: packed element store with push, pop, get and erase
// push and every failing item: result in the cycle after accept, busy stays low
// pop and get: result registered from ST_READ after the memory read, busy high for one cycle
// erase: result registered from ST_READ after the memory read; busy then stays high while
//   later elements move down in ST_SHIFT, one per cycle through the memory ports; busy is
//   high for one cycle only when the last element goes
// reset clears the fill count, state and done flag; the store is not swept; results cannot be stalled
module indexed_stack_with_erase #(
    parameter int DEPTH = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  isw_pkg::req_t req,
    output logic          done,
    output isw_pkg::rsp_t rsp
);
    import isw_pkg::*;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int EXT_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_READ  = 3'b010,
        ST_SHIFT = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    op_t                op_reg, op_next;
    logic [CNT_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic               pend_reg, pend_next;
    logic               done_reg, done_next;
    rsp_t               rsp_reg, rsp_next;

    logic               accept;
    logic               is_full;
    logic               is_empty;
    logic               out_of_range;
    logic [CNT_W-1:0]   fill_dec;
    logic [EXT_W-1:0]   count_ext;

    logic               mem_wr_en;
    logic [ADDR_W-1:0]  mem_wr_addr;
    logic [VALUE_W-1:0] mem_wr_data;
    logic               mem_rd_en;
    logic [ADDR_W-1:0]  mem_rd_addr;
    logic [VALUE_W-1:0] mem_rd_data;

    isw_ram #(
        .DEPTH (DEPTH),
        .WIDTH (VALUE_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // item checks against the fill count
    assign accept       = start && (state_reg == ST_IDLE);
    assign is_full      = (fill_reg == CNT_W'(DEPTH));
    assign is_empty     = (fill_reg == '0);
    assign out_of_range = (CMP_W'(req.index) >= CMP_W'(fill_reg));
    assign fill_dec     = fill_reg - CNT_W'(1);
    assign count_ext    = EXT_W'(fill_next);

    // control sequencer
    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        op_next     = op_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        pend_next   = 1'b0;
        done_next   = 1'b0;
        rsp_next    = rsp_reg;

        mem_wr_en   = 1'b0;
        mem_wr_addr = ADDR_W'(fill_reg);
        mem_wr_data = req.value;
        mem_rd_en   = 1'b0;
        mem_rd_addr = ADDR_W'(req.index);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next              = req.op;
                    wr_ptr_next          = CNT_W'(req.index);
                    rsp_next.read_value  = '0;
                    rsp_next.status      = STS_OK;
                    priority if (req.op == OP_PUSH)
                    begin
                        if (is_full)
                        begin
                            rsp_next.status = STS_FULL;
                        end
                        else
                        begin
                            mem_wr_en = 1'b1;
                            fill_next = fill_reg + CNT_W'(1);
                        end
                        done_next = 1'b1;
                    end
                    else if (is_empty)
                    begin
                        rsp_next.status = STS_EMPTY;
                        done_next       = 1'b1;
                    end
                    else if (req.op == OP_POP)
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = ADDR_W'(fill_dec);
                        fill_next   = fill_dec;
                        state_next  = ST_READ;
                    end
                    else if (out_of_range)
                    begin
                        rsp_next.status = STS_RANGE;
                        done_next       = 1'b1;
                    end
                    else
                    begin
                        mem_rd_en  = 1'b1;
                        if (req.op == OP_ERASE)
                        begin
                            fill_next = fill_dec;
                        end
                        state_next = ST_READ;
                    end
                    rsp_next.count = count_ext[COUNT_W-1:0];
                end
            end

            ST_READ:
            begin
                // read data is back: deliver the item; an erase with later elements then starts moving them
                rsp_next.read_value = mem_rd_data;
                rsp_next.status     = STS_OK;
                rsp_next.count      = count_ext[COUNT_W-1:0];
                done_next           = 1'b1;
                if ((op_reg == OP_ERASE) && (wr_ptr_reg < fill_reg))
                begin
                    rd_ptr_next = wr_ptr_reg + CNT_W'(1);
                    state_next  = ST_SHIFT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_SHIFT:
            begin
                // write the element read last cycle one place lower
                mem_wr_addr = ADDR_W'(wr_ptr_reg);
                mem_wr_data = mem_rd_data;
                if (pend_reg)
                begin
                    mem_wr_en   = 1'b1;
                    wr_ptr_next = wr_ptr_reg + CNT_W'(1);
                end
                // read the next element while any remain
                mem_rd_addr = ADDR_W'(rd_ptr_reg);
                if (rd_ptr_reg <= fill_reg)
                begin
                    mem_rd_en   = 1'b1;
                    rd_ptr_next = rd_ptr_reg + CNT_W'(1);
                    pend_next   = 1'b1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            pend_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            pend_reg   <= pend_next;
            done_reg   <= done_next;
        end
    end

    // item and pointer registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        rd_ptr_reg <= rd_ptr_next;
        wr_ptr_reg <= wr_ptr_next;
        rsp_reg    <= rsp_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ----- test/tb_indexed_stack_with_erase.sv -----
// tb_indexed_stack_with_erase: self-checking testbench for the indexed stack with erase
// drives push, pop, get and erase items and checks every result against a shadow store
// depends on isw_pkg and indexed_stack_with_erase
`timescale 1ns / 1ps

module tb_indexed_stack_with_erase;

    import isw_pkg::*;

    localparam int DEPTH = 1024;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    rsp_t rsp;

    // shadow copy of the block state
    logic signed [VALUE_W-1:0] shadow_store [DEPTH];
    int unsigned               shadow_fill;

    // results still to come, oldest first
    rsp_t awaited_rsp [$];
    rsp_t want;

    int mismatches;
    int items_sent;
    int idle_pct;
    int op_seen [4];
    int status_seen [4];

    indexed_stack_with_erase #(
        .DEPTH(DEPTH)
    ) DUT (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .req  (req),
        .done (done),
        .rsp  (rsp)
    );

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // applies one item to the shadow store and returns the result it must give
    function automatic rsp_t stack_outcome(input req_t item);
        rsp_t r;
        r.read_value = '0;
        r.status     = STS_OK;
        if (item.op == OP_PUSH)
        begin
            if (shadow_fill >= DEPTH)
                r.status = STS_FULL;
            else
            begin
                shadow_store[shadow_fill] = item.value;
                shadow_fill++;
            end
        end
        else if (shadow_fill == 0)
            r.status = STS_EMPTY;
        else if (item.op == OP_POP)
        begin
            shadow_fill--;
            r.read_value = shadow_store[shadow_fill];
        end
        else if (item.index >= shadow_fill)
            r.status = STS_RANGE;
        else if (item.op == OP_GET)
            r.read_value = shadow_store[item.index];
        else
        begin
            // erase: close the gap left at index
            r.read_value = shadow_store[item.index];
            for (int i = item.index + 1; i < shadow_fill; i++)
                shadow_store[i - 1] = shadow_store[i];
            shadow_fill--;
        end
        r.count = COUNT_W'(shadow_fill);
        op_seen[item.op]++;
        status_seen[r.status]++;
        return r;
    endfunction

    function automatic req_t make_req(input op_t op, input logic [VALUE_W-1:0] value,
                                      input logic [INDEX_W-1:0] index);
        req_t r;
        r.op    = op;
        r.value = value;
        r.index = index;
        return r;
    endfunction

    // random item, mostly in-range indices; the push share falls as the store fills
    function automatic req_t random_request();
        req_t        r;
        int unsigned push_w;
        int unsigned pick;
        r.value = $urandom;
        r.index = INDEX_W'($urandom);
        push_w  = (shadow_fill < 48) ? 45 : ((shadow_fill < 160) ? 30 : 5);
        pick    = $urandom_range(99);
        if (pick < push_w)
            r.op = OP_PUSH;
        else
        begin
            pick = $urandom_range(99);
            if (pick < 35)
                r.op = OP_POP;
            else if (pick < 70)
                r.op = OP_GET;
            else
                r.op = OP_ERASE;
        end
        if ((r.op == OP_GET || r.op == OP_ERASE) && shadow_fill != 0
            && $urandom_range(99) < 85)
            r.index = INDEX_W'($urandom_range(shadow_fill - 1));
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatches++;
    endtask

    // hold one item on the request port until the block takes it
    task automatic issue_item(input req_t item);
        start <= 1'b1;
        req   <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        awaited_rsp.push_back(stack_outcome(item));
        items_sent++;
    endtask

    // random idle cycles ahead of an item
    task automatic maybe_pause();
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4))
                @(posedge clk);
        end
    endtask

    // stop sending until every outstanding result has come back
    task automatic wait_for_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (awaited_rsp.size() != 0);
    endtask

    // extremes, every operation, empty and range errors, erase at first, middle and last
    task automatic test_directed_cases();
        issue_item(make_req(OP_POP,   32'h0,        10'h3ff));
        issue_item(make_req(OP_GET,   32'h0,        10'h000));
        // empty wins over a bad index
        issue_item(make_req(OP_ERASE, 32'h0,        10'h3ff));
        issue_item(make_req(OP_PUSH,  32'h7fffffff, 10'h3ff));
        issue_item(make_req(OP_PUSH,  32'h80000000, 10'h155));
        issue_item(make_req(OP_PUSH,  32'h00000000, 10'h2aa));
        issue_item(make_req(OP_PUSH,  32'hffffffff, 10'h000));
        issue_item(make_req(OP_PUSH,  32'h55555555, 10'h001));
        issue_item(make_req(OP_PUSH,  32'haaaaaaaa, 10'h200));
        issue_item(make_req(OP_GET,   32'hffffffff, 10'h000));
        issue_item(make_req(OP_GET,   32'h0,        10'h005));
        issue_item(make_req(OP_GET,   32'h0,        10'h006));
        issue_item(make_req(OP_GET,   32'h0,        10'h3ff));
        issue_item(make_req(OP_ERASE, 32'h0,        10'h3ff));
        issue_item(make_req(OP_ERASE, 32'h0,        10'h002));
        issue_item(make_req(OP_ERASE, 32'h0,        10'h004));
        issue_item(make_req(OP_ERASE, 32'h0,        10'h000));
        issue_item(make_req(OP_GET,   32'h0,        10'h001));
        repeat (4)
            issue_item(make_req(OP_POP, 32'h12345678, 10'h0aa));
        issue_item(make_req(OP_POP,   32'h0,        10'h000));
        wait_for_results();
    endtask

    // fill to capacity, push when full, then work at both ends
    task automatic test_fill_to_capacity();
        while (shadow_fill < DEPTH)
        begin
            maybe_pause();
            issue_item(make_req(OP_PUSH, $urandom, INDEX_W'($urandom)));
        end
        issue_item(make_req(OP_PUSH,  32'h7fffffff, 10'h3ff));
        issue_item(make_req(OP_PUSH,  32'h80000000, 10'h000));
        issue_item(make_req(OP_GET,   32'h0,        10'h3ff));
        issue_item(make_req(OP_GET,   32'h0,        10'h000));
        issue_item(make_req(OP_ERASE, 32'h0,        10'h3ff));
        issue_item(make_req(OP_PUSH,  $urandom,     10'h000));
        // longest shift: every later element moves down
        issue_item(make_req(OP_ERASE, 32'h0,        10'h000));
        issue_item(make_req(OP_PUSH,  $urandom,     10'h000));
        issue_item(make_req(OP_GET,   32'h0,        10'h200));
        wait_for_results();
    endtask

    // random traffic with the given percent chance of idle cycles ahead of each item
    task automatic test_random_traffic(input int n, input int pct);
        idle_pct = pct;
        repeat (n)
        begin
            if ($urandom_range(49) == 0)
                wait_for_results();
            maybe_pause();
            issue_item(random_request());
        end
        wait_for_results();
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (awaited_rsp.size() == 0)
                report_mismatch($sformatf("result with nothing outstanding, status %0d",
                                          rsp.status));
            else
            begin
                want = awaited_rsp.pop_front();
                if (rsp.read_value !== want.read_value)
                    report_mismatch($sformatf("read_value %0h, expected %0h",
                                              rsp.read_value, want.read_value));
                if (rsp.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              rsp.status, want.status));
                if (rsp.count !== want.count)
                    report_mismatch($sformatf("count %0d, expected %0d",
                                              rsp.count, want.count));
            end
        end
    end

    // main sequence
    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        req         = '0;
        shadow_fill = 0;
        mismatches  = 0;
        items_sent  = 0;
        idle_pct    = 0;
        foreach (op_seen[i])
            op_seen[i] = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_traffic(215, 0);
        test_random_traffic(215, 69);
        test_random_traffic(215, 26);
        test_fill_to_capacity();

        // trailing erase shift plus margin for any stray result
        repeat (DEPTH + 16)
            @(posedge clk);
        if (awaited_rsp.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", awaited_rsp.size()));

        $display("covered %0d items: push %0d, pop %0d, get %0d, erase %0d",
                 items_sent, op_seen[OP_PUSH], op_seen[OP_POP], op_seen[OP_GET],
                 op_seen[OP_ERASE]);
        $display("outcomes: ok %0d, full %0d, empty %0d, out of range %0d; mismatches %0d",
                 status_seen[STS_OK], status_seen[STS_FULL], status_seen[STS_EMPTY],
                 status_seen[STS_RANGE], mismatches);
        if (mismatches == 0)
            $display("tb_indexed_stack_with_erase: done, clean");
        else
            $display("tb_indexed_stack_with_erase: done, errors");
        $finish;
    end

    // watchdog
    initial
    begin
        #40_000_000;
        $display("timeout with %0d results outstanding", awaited_rsp.size());
        $display("tb_indexed_stack_with_erase: done, errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/isw_pkg.sv
rtl/core/isw_ram.sv
rtl/core/indexed_stack_with_erase.sv
test/tb_indexed_stack_with_erase.sv
